// File: hw/rtl/vector_matrix_transform_top_defines.svh
// Assertion macros used by the checker of the vector matrix transform.
`ifndef VECTOR_MATRIX_TRANSFORM_TOP_DEFINES_SVH
`define VECTOR_MATRIX_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VMT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vmt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vmt assertion failed");

`endif

// File: hw/rtl/vmt_pkg.sv
// Types and constants of the vector matrix transform.
`default_nettype none

package vmt_pkg;

  localparam int DATA_W     = 16;
  localparam int COEFF_W    = 16;
  localparam int COEFF_FRAC = COEFF_W - 4;
  localparam int SLOT_W     = 16;
  localparam int LANES      = 4;
  localparam int CFG_W      = LANES * SLOT_W;
  localparam int CFG_IDX_W  = 8;
  localparam int LANE_IDX_W = $clog2(LANES);
  localparam int PROD_W     = DATA_W + COEFF_W;
  localparam int SUM_W      = PROD_W + $clog2(LANES);

  localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]  SUM_MAX = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0]  SUM_MIN = SUM_W'(OUT_MIN);

  // Unity coefficient in one slot.
  localparam logic [SLOT_W-1:0] COEFF_ONE = SLOT_W'(1) << COEFF_FRAC;

  typedef struct packed {
    logic                     last;
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] x;
  } vmt_in_t;

  typedef struct packed {
    logic                     last;
    logic                     clamped;
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] x;
  } vmt_out_t;

  // Sideband that travels alongside the lane pipelines.
  typedef struct packed {
    logic valid;
    logic last;
  } vmt_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/vmt_lane.sv
// One dot-product lane: four multipliers, an adder tree, shift and saturate.
`default_nettype none

module vmt_lane (
  input  wire logic                              clk,
  input  wire vmt_pkg::vmt_in_t                  vec,
  input  wire logic [vmt_pkg::CFG_W-1:0]         coeffs,
  output logic signed [vmt_pkg::DATA_W-1:0]      res,
  output logic                                   clamp
);

  logic signed [vmt_pkg::DATA_W-1:0]  comp     [vmt_pkg::LANES];
  logic signed [vmt_pkg::COEFF_W-1:0] coef     [vmt_pkg::LANES];
  logic signed [vmt_pkg::PROD_W-1:0]  prod_nxt [vmt_pkg::LANES];
  logic signed [vmt_pkg::PROD_W-1:0]  prod_r   [vmt_pkg::LANES];
  logic signed [vmt_pkg::SUM_W-1:0]   sum_nxt;
  logic signed [vmt_pkg::SUM_W-1:0]   sum_r;
  logic signed [vmt_pkg::SUM_W-1:0]   shifted;

  assign comp[0] = vec.x;
  assign comp[1] = vec.y;
  assign comp[2] = vec.z;
  assign comp[3] = vec.w;

  always_comb begin
    for (int k = 0; k < vmt_pkg::LANES; k++) begin
      // slot bits above the coefficient width are ignored
      coef[k]     = $signed(coeffs[k*vmt_pkg::SLOT_W +: vmt_pkg::COEFF_W]);
      prod_nxt[k] = comp[k] * coef[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < vmt_pkg::LANES; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
  end

  assign sum_nxt = vmt_pkg::SUM_W'(prod_r[0]) + vmt_pkg::SUM_W'(prod_r[1])
                 + vmt_pkg::SUM_W'(prod_r[2]) + vmt_pkg::SUM_W'(prod_r[3]);

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // arithmetic shift truncates toward minus infinity
  assign shifted = sum_r >>> vmt_pkg::COEFF_FRAC;

  always_comb begin
    if (shifted > vmt_pkg::SUM_MAX) begin
      res   = vmt_pkg::OUT_MAX;
      clamp = 1'b1;
    end else if (shifted < vmt_pkg::SUM_MIN) begin
      res   = vmt_pkg::OUT_MIN;
      clamp = 1'b1;
    end else begin
      res   = shifted[vmt_pkg::DATA_W-1:0];
      clamp = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vmt_merge.sv
// Collects the four lane results into one registered result with its flags.
`default_nettype none

module vmt_merge (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic signed [vmt_pkg::DATA_W-1:0] lane_res [vmt_pkg::LANES],
  input  wire logic [vmt_pkg::LANES-1:0]    lane_clamp,
  input  wire vmt_pkg::vmt_ctl_t            ctl,
  output vmt_pkg::vmt_out_t                 out_data,
  output logic                              out_valid
);

  vmt_pkg::vmt_out_t out_nxt;
  vmt_pkg::vmt_out_t out_r;
  logic              valid_r;

  always_comb begin
    out_nxt.x       = lane_res[0];
    out_nxt.y       = lane_res[1];
    out_nxt.z       = lane_res[2];
    out_nxt.w       = lane_res[3];
    out_nxt.clamped = |lane_clamp;
    out_nxt.last    = ctl.last;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.valid;
    end
  end

  assign out_data  = out_r;
  assign out_valid = valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/vector_matrix_transform_top.sv
// Top level of the vector matrix transform: config registers, lanes, merge.
`default_nettype none

// Transforms one four-component Q8.8 vector per clock cycle by the 4x4 Q4.12
// matrix held in the four coefficient registers; busy never rises, so a
// request can be issued every cycle. Each result appears for one cycle with
// out_valid after the multiplier and adder-tree stages of the four lanes and
// the saturate-and-merge stage, in request order. The receiver cannot stall
// the block. Coefficient writes are always accepted (cfg_ready is high) and
// should be made while no request is in flight; writes to an index beyond
// the fourth register are dropped.

module vector_matrix_transform_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire vmt_pkg::vmt_in_t                in_data,
  output logic                                 out_valid,
  output vmt_pkg::vmt_out_t                    out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vmt_pkg::CFG_W-1:0]       cfg_data
);

  logic [vmt_pkg::CFG_W-1:0]        coeff_r [vmt_pkg::LANES];
  logic signed [vmt_pkg::DATA_W-1:0] lane_res [vmt_pkg::LANES];
  logic [vmt_pkg::LANES-1:0]        lane_clamp;
  vmt_pkg::vmt_ctl_t                ctl_nxt;
  vmt_pkg::vmt_ctl_t                ctl1_r;
  vmt_pkg::vmt_ctl_t                ctl2_r;
  logic                             accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // identity matrix
      for (int c = 0; c < vmt_pkg::LANES; c++) begin
        coeff_r[c] <= vmt_pkg::CFG_W'(vmt_pkg::COEFF_ONE) << (c * vmt_pkg::SLOT_W);
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < vmt_pkg::CFG_IDX_W'(vmt_pkg::LANES)) begin
      coeff_r[cfg_index[vmt_pkg::LANE_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign ctl_nxt.valid = accept;
  assign ctl_nxt.last  = in_data.last;

  // sideband follows the multiplier and adder stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  for (genvar c = 0; c < vmt_pkg::LANES; c++) begin : g_lane
    vmt_lane u_lane (
      .clk    (clk),
      .vec    (in_data),
      .coeffs (coeff_r[c]),
      .res    (lane_res[c]),
      .clamp  (lane_clamp[c])
    );
  end

  vmt_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_res   (lane_res),
    .lane_clamp (lane_clamp),
    .ctl        (ctl2_r),
    .out_data   (out_data),
    .out_valid  (out_valid)
  );

endmodule

`default_nettype wire

// File: hw/rtl/vmt_checker.sv
// Port-level checks of the vector matrix transform, bound to the top level.
`default_nettype none

`include "vector_matrix_transform_top_defines.svh"

module vmt_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire vmt_pkg::vmt_in_t  in_data,
  input wire logic              out_valid,
  input wire vmt_pkg::vmt_out_t out_data
);

  // every accepted request yields a result once it has passed the pipeline
  `VMT_ASSERT_NOW(a_latency, start && !busy, ##3 out_valid)

  // no result without a matching earlier request
  `VMT_ASSERT_NOW(a_no_spurious, out_valid, $past(start && !busy, 3))

  // the last marker rides with its request
  `VMT_ASSERT_NOW(a_last_tracks, out_valid, out_data.last == $past(in_data.last, 3))

  // a clamp flag means some component sits at a rail
  `VMT_ASSERT_NOW(a_clamp_rail, out_valid && out_data.clamped,
    out_data.x == vmt_pkg::OUT_MAX || out_data.x == vmt_pkg::OUT_MIN ||
    out_data.y == vmt_pkg::OUT_MAX || out_data.y == vmt_pkg::OUT_MIN ||
    out_data.z == vmt_pkg::OUT_MAX || out_data.z == vmt_pkg::OUT_MIN ||
    out_data.w == vmt_pkg::OUT_MAX || out_data.w == vmt_pkg::OUT_MIN)

endmodule

bind vector_matrix_transform_top vmt_checker u_vmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
